[hw/rtl/glbp_pkg.sv]
package glbp_pkg;

    localparam int unsigned PixelWidth = 8;
    localparam int unsigned BppWidth   = 4;
    localparam int unsigned HeldWidth  = 3;
    localparam int unsigned FifoDepth  = 4;
    localparam int unsigned PtrWidth   = $clog2(FifoDepth);
    localparam int unsigned CountWidth = $clog2(FifoDepth + 1);

    localparam logic [BppWidth-1:0] BppReset = 4'd8;
    localparam logic [BppWidth-1:0] BppMax   = 4'd8;

    typedef struct packed {
        logic [PixelWidth-1:0] pixel;
        logic                  last_pixel;
    } pixel_word_t;

    typedef struct packed {
        logic [PixelWidth-1:0] packed_byte;
        logic                  last_byte;
    } byte_word_t;

endpackage

[hw/rtl/gray_level_bit_packer.sv]
// Gray level bit packer.
// Input channel (in_valid / in_stall / in_data): one word per pixel, carrying
// the 8-bit gray value and a flag on the final pixel of the image. The top
// bits_per_pixel bits of each pixel are appended MSB-first to a byte
// accumulator; each byte that fills is sent on the output channel
// (out_valid / out_stall / out_data). On the final pixel any partial byte is
// left-aligned, zero padded and sent with last_byte set.
// One pixel is accepted per cycle while in_stall is low. Its bytes (zero, one
// or two) enter a four-entry output queue together; if the queue was empty,
// the first is offered in the cycle after the pixel is taken, the second after it.
// in_stall rises while fewer than two queue entries are free, so a stalled
// receiver backs up into the input once three words are waiting.
// cfg_write loads bits_per_pixel from cfg_data (values above 8 act as 8); a
// new value applies from the next pixel on.
// Reset empties the queue, clears the accumulator and sets bits_per_pixel
// to 8.
module gray_level_bit_packer
    import glbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [BppWidth-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  pixel_word_t         in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output byte_word_t          out_data
);

    logic [BppWidth-1:0]   bpp_reg;
    logic [PixelWidth-1:0] acc_reg, acc_next;
    logic [HeldWidth-1:0]  held_reg, held_next;

    byte_word_t            fifo_mem [FifoDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0] count_reg, count_next;

    logic                      in_accept;
    logic                      out_accept;
    logic [BppWidth-1:0]       n_bits;
    logic [PixelWidth-1:0]     top_bits;
    logic [2*PixelWidth-1:0]   merged;
    logic [BppWidth-1:0]       total;
    logic [HeldWidth-1:0]      rem;
    logic                      full_byte;
    logic [PixelWidth-1:0]     done_byte;
    logic [PixelWidth-1:0]     acc_mid;
    logic [HeldWidth-1:0]      held_mid;
    logic [PixelWidth-1:0]     flush_byte;
    byte_word_t                push_a;
    byte_word_t                push_b;
    logic [1:0]                n_push;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = count_reg > CountWidth'(FifoDepth - 2);
    assign out_valid  = count_reg != '0;
    assign out_data   = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        n_bits   = (bpp_reg > BppMax) ? BppMax : bpp_reg;
        top_bits = (n_bits == '0) ? '0 : (in_data.pixel >> (BppMax - n_bits));
        merged   = ({8'd0, acc_reg} << n_bits) | {8'd0, top_bits};
        total    = {1'b0, held_reg} + n_bits;
        full_byte = total >= BppMax;
        rem       = total[HeldWidth-1:0];
        done_byte = PixelWidth'(merged >> rem);

        if (full_byte)
        begin
            acc_mid  = PixelWidth'(merged) & ((8'd1 << rem) - 8'd1);
            held_mid = rem;
        end
        else
        begin
            acc_mid  = PixelWidth'(merged);
            held_mid = total[HeldWidth-1:0];
        end

        flush_byte = PixelWidth'(acc_mid << (BppMax - {1'b0, held_mid}));

        push_a = '{packed_byte: done_byte, last_byte: 1'b0};
        push_b = '{packed_byte: flush_byte, last_byte: 1'b1};
        n_push = '0;
        acc_next  = acc_reg;
        held_next = held_reg;

        if (in_accept)
        begin
            acc_next  = acc_mid;
            held_next = held_mid;
            if (full_byte)
            begin
                n_push = 2'd1;
            end
            if (in_data.last_pixel)
            begin
                acc_next  = '0;
                held_next = '0;
                if (held_mid != '0)
                begin
                    if (full_byte)
                    begin
                        n_push = 2'd2;
                    end
                    else
                    begin
                        push_a = push_b;
                        n_push = 2'd1;
                    end
                end
                else
                begin
                    push_a.last_byte = full_byte;
                end
            end
        end

        wr_ptr_next = wr_ptr_reg + PtrWidth'(n_push);
        rd_ptr_next = rd_ptr_reg + PtrWidth'(out_accept);
        count_next  = count_reg + CountWidth'(n_push) - CountWidth'(out_accept);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    <= BppReset;
            acc_reg    <= '0;
            held_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                bpp_reg <= cfg_data;
            end
            acc_reg    <= acc_next;
            held_reg   <= held_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != '0)
        begin
            fifo_mem[wr_ptr_reg] <= push_a;
        end
        if (n_push == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PtrWidth'(1)] <= push_b;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountWidth'(FifoDepth))
        else $error("output queue count exceeds depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_data.last_pixel |=> held_reg == '0 && acc_reg == '0)
        else $error("accumulator not cleared after final pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[PtrWidth-1:0] == PtrWidth'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> count_reg == $past(count_reg) + CountWidth'($past(n_push))
                                   - CountWidth'($past(out_accept)))
        else $error("queue count update mismatch");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import glbp_pkg::*;

    localparam int CycleLimit  = 300000;
    localparam int DrainCycles = 8;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [BppWidth-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    pixel_word_t         in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b1;
    byte_word_t          out_data;

    byte_word_t          expected_bytes[$];
    logic [BppWidth-1:0] bpp_setting = BppReset;
    logic [7:0]          acc_bits = '0;
    logic [2:0]          held_count = '0;

    int send_idle_pct = 37;
    int recv_stall_pct = 37;
    int hold_cycles = 0;
    int sent_pixels = 0;
    int err_count = 0;
    int cycle_count = 0;

    gray_level_bit_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic void pack_pixel(input pixel_word_t w);
        logic [BppWidth-1:0] n;
        logic [7:0]          top;
        logic [15:0]         merged;
        int                  total;
        int                  rem;
        byte_word_t          done;
        byte_word_t          flush;
        bit                  have_done;
        n = (bpp_setting > BppMax) ? BppMax : bpp_setting;
        top = (n == 0) ? 8'h00 : 8'(w.pixel >> (PixelWidth - n));
        merged = ({8'h00, acc_bits} << n) | {8'h00, top};
        total = int'(held_count) + int'(n);
        have_done = 1'b0;
        done = '0;
        if (total >= 8)
        begin
            rem = total - 8;
            done.packed_byte = 8'(merged >> rem);
            done.last_byte = 1'b0;
            have_done = 1'b1;
            acc_bits = 8'(merged & ((16'd1 << rem) - 16'd1));
            held_count = 3'(rem);
        end
        else
        begin
            acc_bits = merged[7:0];
            held_count = 3'(total);
        end
        if (w.last_pixel)
        begin
            if (held_count != 0)
            begin
                if (have_done)
                    expected_bytes.push_back(done);
                flush.packed_byte = 8'(acc_bits << (8 - held_count));
                flush.last_byte = 1'b1;
                expected_bytes.push_back(flush);
            end
            else if (have_done)
            begin
                done.last_byte = 1'b1;
                expected_bytes.push_back(done);
            end
            acc_bits = '0;
            held_count = '0;
        end
        else if (have_done)
            expected_bytes.push_back(done);
    endfunction

    // receiver: random stalls, or a counted hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        byte_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected word: packed_byte %02h last_byte %0b",
                       out_data.packed_byte, out_data.last_byte);
                err_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_data.packed_byte !== want.packed_byte)
                begin
                    $error("packed_byte: expected %02h, got %02h",
                           want.packed_byte, out_data.packed_byte);
                    err_count++;
                end
                if (out_data.last_byte !== want.last_byte)
                begin
                    $error("last_byte: expected %0b, got %0b",
                           want.last_byte, out_data.last_byte);
                    err_count++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(input logic [7:0] pix, input logic last);
        pixel_word_t w;
        w.pixel = pix;
        w.last_pixel = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        pack_pixel(w);
        sent_pixels++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_bpp(input logic [BppWidth-1:0] value);
        wait_drain();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        bpp_setting = value;
    endtask

    function automatic logic [7:0] random_pixel();
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [BppWidth-1:0] random_bpp();
        int r;
        r = $urandom_range(9);
        if (r < 8)
            return BppWidth'(r + 1);
        if (r == 8)
            return '0;
        return BppWidth'($urandom_range(15, 9));
    endfunction

    task automatic send_image(input int len, input int rewrite_at);
        for (int i = 0; i < len; i++)
        begin
            if (i == rewrite_at)
                write_bpp(random_bpp());
            send_pixel(random_pixel(), i == len - 1);
        end
    endtask

    task automatic test_directed();
        // full bytes at reset width, last one closes exactly
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b1);
        write_bpp(4'd1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h7F, 1'b1);
        // zero width: nothing appended, nothing emitted
        write_bpp(4'd0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hAA, 1'b1);
        // full byte plus flush from one pixel
        write_bpp(4'd3);
        send_pixel(8'hE0, 1'b0);
        send_pixel(8'h5F, 1'b0);
        send_pixel(8'hFF, 1'b1);
        // width above eight saturates
        write_bpp(4'd15);
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'h3C, 1'b1);
        // width change mid-image keeps pending bits
        write_bpp(4'd5);
        send_pixel(8'hF8, 1'b0);
        write_bpp(4'd7);
        send_pixel(8'h81, 1'b1);
        // zero width mid-image, then flush what is pending
        write_bpp(4'd2);
        send_pixel(8'hC0, 1'b0);
        write_bpp(4'd0);
        send_pixel(8'h12, 1'b1);
        write_bpp(4'd8);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'hFE, 1'b1);
    endtask

    task automatic test_random_images(input int target);
        int len;
        while (sent_pixels < target)
        begin
            write_bpp(random_bpp());
            len = ($urandom_range(7) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
            send_image(len, ($urandom_range(7) == 0) ? $urandom_range(len - 1) : -1);
        end
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_bpp(4'd5);
        for (int k = 0; k < 10; k++)
            send_image(20, -1);
        write_bpp(4'd8);
        send_image(60, -1);
        send_idle_pct = 37;
        recv_stall_pct = 37;
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        write_bpp(4'd8);
        hold_cycles = 80;
        send_image(40, -1);
        // pause until every byte is out
        wait_drain();
        write_bpp(4'd3);
        hold_cycles = 60;
        send_image(50, -1);
        wait_drain();
        send_idle_pct = 37;
        send_image(30, -1);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_images(1550);
        test_no_idle();
        test_backpressure();
        wait_drain();
        repeat (20) @(negedge clk);
        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[gray_level_bit_packer.f]
hw/rtl/glbp_pkg.sv
hw/rtl/gray_level_bit_packer.sv
sim/testbench.sv
